FILE: sv/difficulty_retarget_core_assert.svh
// ----------------------------------------------------------------------------
// Difficulty retarget core assertion macros
// Concurrent assertion helpers used by the top RTL file of the core.
// ----------------------------------------------------------------------------
`ifndef DIFFICULTY_RETARGET_CORE_ASSERT_SVH
`define DIFFICULTY_RETARGET_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define DRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define DRC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/drc_pkg.sv
// ----------------------------------------------------------------------------
// Difficulty retarget package
// Widths, constants, payload types and the compact word unpack function.
// ----------------------------------------------------------------------------
package drc_pkg;

   localparam int COMPACT_W   = 32;
   localparam int TIME_W      = 32;
   localparam int SPAN_W      = 30;
   localparam int MANT_W      = 24;
   localparam int EXP_W       = 8;
   localparam int SHIFT_W     = 5;
   localparam int PROD_W      = MANT_W + TIME_W;
   localparam int FRAC_BITS   = 64;
   localparam int QUOT_W      = PROD_W + FRAC_BITS;
   localparam int QUOT_BYTES  = QUOT_W / 8;
   localparam int NQ_W        = 6;
   localparam int MAX_BYTES   = 32;
   localparam int CSR_INDEX_W = 1;

   localparam int DIV_BITS_DEFAULT = 4;

   localparam logic [COMPACT_W-1:0] LIMIT_RESET    = 32'h1d00ffff;
   localparam logic [SPAN_W-1:0]    TIMESPAN_RESET = 30'd1209600;
   localparam logic [EXP_W-1:0]     EXP_SMALL_MAX  = 8'd3;
   localparam logic [EXP_W-1:0]     EXP_LARGE_MAX  = 8'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_TIMESPAN = 1'b0,
      CSR_LIMIT_BITS      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COMPACT_W-1:0] prior_compact;
      logic [TIME_W-1:0]    window_start_time;
      logic [TIME_W-1:0]    window_end_time;
   } req_payload_type;

   typedef struct packed {
      logic [COMPACT_W-1:0] next_compact;
      logic                 hit_limit;
   } rsp_payload_type;

   typedef struct packed {
      logic [PROD_W-1:0]  product;
      logic [SHIFT_W-1:0] shift_bytes;
   } prod_type;

   typedef struct packed {
      logic [SPAN_W-1:0]  rem;
      logic [QUOT_W-1:0]  work;
      logic [SHIFT_W-1:0] shift_bytes;
   } div_state_type;

   // A compact word is value = mant << (8 * shift_bytes); small exponents are
   // folded into a right-shifted mantissa, oversized exponents give zero.
   typedef struct packed {
      logic [MANT_W-1:0]  mant;
      logic [SHIFT_W-1:0] shift_bytes;
   } unpacked_type;

   function automatic unpacked_type compact_unpack(input logic [COMPACT_W-1:0] bits);
      unpacked_type            res;
      logic [EXP_W-1:0]        e;
      logic [MANT_W-1:0]       m;
      e = bits[COMPACT_W-1 -: EXP_W];
      m = bits[MANT_W-1:0];
      if (e <= EXP_SMALL_MAX) begin
         res.mant        = m >> {2'd3 - e[1:0], 3'b000};
         res.shift_bytes = '0;
      end else if (e <= EXP_LARGE_MAX) begin
         res.mant        = m;
         res.shift_bytes = SHIFT_W'(e - EXP_SMALL_MAX);
      end else begin
         res.mant        = '0;
         res.shift_bytes = '0;
      end
      return res;
   endfunction

endpackage

FILE: sv/drc_stream_if.sv
// ----------------------------------------------------------------------------
// Difficulty retarget stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface drc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/drc_prep.sv
// ----------------------------------------------------------------------------
// Difficulty retarget front end
// Clamps the elapsed time, unpacks the prior word and forms mantissa * time.
// ----------------------------------------------------------------------------
module drc_prep
   import drc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SPAN_W-1:0] divisor,
   drc_stream_if.sink        up,
   drc_stream_if.source      down
);

   logic                 v0_ff, v1_ff;
   logic                 en0, en1;
   logic [MANT_W-1:0]    mant_ff;
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic [SHIFT_W-1:0]   shift_ff;
   prod_type             prod_ff, prod_in;
   unpacked_type         prior_in;
   logic [TIME_W-1:0]    span_lo, span_hi, diff;

   assign en1      = !v1_ff || down.ready;
   assign en0      = !v0_ff || en1;
   assign up.ready = en0;

   always_comb begin
      span_lo  = {2'b00, divisor >> 2};
      span_hi  = {divisor, 2'b00};
      diff     = up.payload.window_end_time - up.payload.window_start_time;
      prior_in = compact_unpack(up.payload.prior_compact);
      if (diff < span_lo) begin
         elapsed_in = span_lo;
      end else if (diff > span_hi) begin
         elapsed_in = span_hi;
      end else begin
         elapsed_in = diff;
      end
   end

   always_comb begin
      prod_in.product     = PROD_W'(mant_ff) * PROD_W'(elapsed_ff);
      prod_in.shift_bytes = shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= up.valid;
         if (en1) v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         mant_ff    <= prior_in.mant;
         shift_ff   <= prior_in.shift_bytes;
         elapsed_ff <= elapsed_in;
      end
      if (en1) prod_ff <= prod_in;
   end

   assign down.valid   = v1_ff;
   assign down.payload = prod_ff;

endmodule

FILE: sv/drc_div_stage.sv
// ----------------------------------------------------------------------------
// Difficulty retarget divider stage
// Retires BITS restoring-division quotient bits, then registers the state.
// ----------------------------------------------------------------------------
module drc_div_stage
   import drc_pkg::*;
#(
   parameter int BITS = DIV_BITS_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SPAN_W-1:0] divisor,
   drc_stream_if.sink        up,
   drc_stream_if.source      down
);

   logic          valid_ff;
   logic          enable;
   div_state_type state_ff, state_in;

   assign enable   = !valid_ff || down.ready;
   assign up.ready = enable;

   // The work word shifts dividend bits out at the top and quotient bits in
   // at the bottom, so after all stages it holds the quotient.
   always_comb begin : step
      logic [SPAN_W:0]   trial;
      logic [SPAN_W-1:0] rem;
      logic [QUOT_W-1:0] work;
      logic              qbit;
      rem  = up.payload.rem;
      work = up.payload.work;
      for (int i = 0; i < BITS; i++) begin
         trial = {rem, work[QUOT_W-1]};
         qbit  = (trial >= {1'b0, divisor});
         if (qbit) begin
            rem = SPAN_W'(trial - {1'b0, divisor});
         end else begin
            rem = trial[SPAN_W-1:0];
         end
         work = {work[QUOT_W-2:0], qbit};
      end
      state_in             = up.payload;
      state_in.rem         = rem;
      state_in.work        = work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) state_ff <= state_in;
   end

   assign down.valid   = valid_ff;
   assign down.payload = state_ff;

endmodule

FILE: sv/drc_divider.sv
// ----------------------------------------------------------------------------
// Difficulty retarget divider
// Pipelined restoring division of (product << 64) by the timespan.
// ----------------------------------------------------------------------------
module drc_divider
   import drc_pkg::*;
#(
   parameter int BITS_PER_STAGE = DIV_BITS_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SPAN_W-1:0] divisor,
   drc_stream_if.sink        up,
   drc_stream_if.source      down
);

   localparam int STAGES = QUOT_W / BITS_PER_STAGE;

   drc_stream_if #(.payload_type(div_state_type)) link [STAGES+1] ();

   assign link[0].valid   = up.valid;
   assign up.ready        = link[0].ready;
   assign link[0].payload = '{rem:         '0,
                              work:        {up.payload.product, {FRAC_BITS{1'b0}}},
                              shift_bytes: up.payload.shift_bytes};

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      drc_div_stage #(.BITS(BITS_PER_STAGE)) u_stage (
         .clock   (clock),
         .reset   (reset),
         .divisor (divisor),
         .up      (link[s]),
         .down    (link[s+1])
      );
   end

   assign down.valid           = link[STAGES].valid;
   assign link[STAGES].ready   = down.ready;
   assign down.payload         = link[STAGES].payload;

endmodule

FILE: sv/drc_encode.sv
// ----------------------------------------------------------------------------
// Difficulty retarget encoder
// Normalizes the quotient, compares it with the limit and packs the result.
// ----------------------------------------------------------------------------
module drc_encode
   import drc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SPAN_W-1:0]    divisor,
   input  logic [COMPACT_W-1:0] limit_bits,
   drc_stream_if.sink           up,
   drc_stream_if.source         down
);

   localparam int FRAC_BYTES  = FRAC_BITS / 8;
   localparam int SCALE_W     = SPAN_W + MANT_W;
   localparam int STICKY_FROM = FRAC_BYTES + 4;

   logic va_ff, vb_ff, vc_ff;
   logic ena, enb, enc;

   logic [QUOT_W-1:0]    qt_ff, qt_in;
   logic [SHIFT_W-1:0]   shift_ff;
   logic                 low_ff, low_in;
   logic [NQ_W-1:0]      nq_ff, nq_in;
   logic [MANT_W-1:0]    mq_ff, mq_in;
   logic                 sticky_ff, sticky_in;
   rsp_payload_type      rsp_ff, rsp_in;

   assign enc      = !vc_ff || down.ready;
   assign enb      = !vb_ff || enc;
   assign ena      = !va_ff || enb;
   assign up.ready = ena;

   function automatic logic [1:0] byte_len24(input logic [MANT_W-1:0] v);
      logic [1:0] n;
      n = 2'd0;
      if (|v[7:0])   n = 2'd1;
      if (|v[15:8])  n = 2'd2;
      if (|v[23:16]) n = 2'd3;
      return n;
   endfunction

   // Stage A: for small shifts the quotient bits below the binary point are
   // dropped; for large shifts the remainder decides whether any bits of the
   // true quotient lie below the computed ones.
   always_comb begin : stage_a
      logic [SHIFT_W-1:0] k;
      logic [6:0]         cut;
      logic [4:0]         m;
      logic [SCALE_W-1:0] scaled;
      k      = up.payload.shift_bytes;
      cut    = 7'(FRAC_BITS) - {1'b0, k[2:0], 3'b000};
      m      = {k[1:0], 3'b000};
      scaled = {{MANT_W{1'b0}}, up.payload.rem} << m;
      if (k < SHIFT_W'(FRAC_BYTES)) begin
         qt_in  = up.payload.work & ({QUOT_W{1'b1}} << cut);
         low_in = 1'b0;
      end else if (k < SHIFT_W'(STICKY_FROM)) begin
         qt_in  = up.payload.work;
         low_in = (scaled >= {{MANT_W{1'b0}}, divisor});
      end else begin
         qt_in  = up.payload.work;
         low_in = (up.payload.rem != '0);
      end
   end

   // Stage B: byte length and top three bytes of the quotient.
   always_comb begin : stage_b
      logic [3:0]        nbytes;
      logic [QUOT_W-1:0] norm;
      logic [6:0]        total;
      nbytes = 4'd0;
      for (int b = 0; b < QUOT_BYTES; b++) begin
         if (|qt_ff[8*b +: 8]) nbytes = 4'(b + 1);
      end
      norm      = qt_ff << {4'(QUOT_BYTES) - nbytes, 3'b000};
      mq_in     = norm[QUOT_W-1 -: MANT_W];
      sticky_in = (|norm[QUOT_W-MANT_W-1:0]) || low_ff;
      total     = {3'b000, nbytes} + {2'b00, shift_ff} - 7'(FRAC_BYTES);
      nq_in     = (qt_ff == '0) ? '0 : total[NQ_W-1:0];
   end

   // Stage C: exact compare against the limit, then compact packing.
   always_comb begin : stage_c
      unpacked_type      lim;
      logic [1:0]        lb;
      logic [NQ_W-1:0]   nl;
      logic [MANT_W-1:0] mlw;
      logic              hit;
      logic [NQ_W-1:0]   n_enc;
      logic [MANT_W-1:0] m_enc;
      lim = compact_unpack(limit_bits);
      lb  = byte_len24(lim.mant);
      nl  = (lim.mant == '0) ? '0 : NQ_W'(lb) + NQ_W'(lim.shift_bytes);
      mlw = lim.mant << {2'd3 - lb, 3'b000};
      hit = (nq_ff > NQ_W'(MAX_BYTES)) || (nq_ff > nl) ||
            ((nq_ff == nl) && ((mq_ff > mlw) || ((mq_ff == mlw) && sticky_ff)));
      if (mq_ff[MANT_W-1]) begin
         n_enc = nq_ff + NQ_W'(1);
         m_enc = mq_ff >> 8;
      end else begin
         n_enc = nq_ff;
         m_enc = mq_ff;
      end
      rsp_in.hit_limit    = hit;
      rsp_in.next_compact = hit ? limit_bits : {2'b00, n_enc, m_enc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ena) va_ff <= up.valid;
         if (enb) vb_ff <= va_ff;
         if (enc) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ena) begin
         qt_ff    <= qt_in;
         shift_ff <= up.payload.shift_bytes;
         low_ff   <= low_in;
      end
      if (enb) begin
         nq_ff     <= nq_in;
         mq_ff     <= mq_in;
         sticky_ff <= sticky_in;
      end
      if (enc) rsp_ff <= rsp_in;
   end

   assign down.valid   = vc_ff;
   assign down.payload = rsp_ff;

endmodule

FILE: sv/difficulty_retarget_core.sv
// Pipeline: a request passes through the registered front end, the divider
// stages and the encoder stages before its response becomes valid.
// Throughput: one request per cycle unless rsp_chan stalls; the 120-bit
// quotient divider is fully pipelined and every stage holds its own valid bit
// under backpressure. Reset (synchronous, active high) empties the pipeline
// and restores the timespan to 1209600 and the limit word to 0x1d00ffff.
// ----------------------------------------------------------------------------
// Difficulty retarget core
// Scales a compact target by clamped elapsed time over the target timespan, capped at the limit.
// ----------------------------------------------------------------------------
`include "difficulty_retarget_core_assert.svh"

module difficulty_retarget_core
   import drc_pkg::*;
#(
   parameter int DIV_BITS_PER_STAGE = DIV_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COMPACT_W-1:0]   csr_write_data,
   drc_stream_if.sink             req_chan,
   drc_stream_if.source           rsp_chan
);

   logic [SPAN_W-1:0]    timespan_ff;
   logic [COMPACT_W-1:0] limit_bits_ff;
   logic [SPAN_W-1:0]    divisor;

   drc_stream_if #(.payload_type(prod_type))      prod_link ();
   drc_stream_if #(.payload_type(div_state_type)) quot_link ();

   // A zero timespan divides by one, which narrows the clamp to the range 0 to 4.
   assign divisor = (timespan_ff == '0) ? SPAN_W'(1) : timespan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timespan_ff   <= TIMESPAN_RESET;
         limit_bits_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET_TIMESPAN: timespan_ff   <= csr_write_data[SPAN_W-1:0];
            CSR_LIMIT_BITS:      limit_bits_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   drc_prep u_prep (
      .clock   (clock),
      .reset   (reset),
      .divisor (divisor),
      .up      (req_chan),
      .down    (prod_link)
   );

   drc_divider #(.BITS_PER_STAGE(DIV_BITS_PER_STAGE)) u_divider (
      .clock   (clock),
      .reset   (reset),
      .divisor (divisor),
      .up      (prod_link),
      .down    (quot_link)
   );

   drc_encode u_encode (
      .clock      (clock),
      .reset      (reset),
      .divisor    (divisor),
      .limit_bits (limit_bits_ff),
      .up         (quot_link),
      .down       (rsp_chan)
   );

   `DRC_ASSERT_IMPLY(a_hit_gives_limit, clock, reset, rsp_chan.valid && rsp_chan.payload.hit_limit, rsp_chan.payload.next_compact == limit_bits_ff)
   `DRC_ASSERT_IMPLY(a_mant_sign_clear, clock, reset, rsp_chan.valid && !rsp_chan.payload.hit_limit, !rsp_chan.payload.next_compact[MANT_W-1])
   `DRC_ASSERT_IMPLY(a_zero_is_zero, clock, reset, rsp_chan.valid && !rsp_chan.payload.hit_limit && (rsp_chan.payload.next_compact[MANT_W-1:0] == '0), rsp_chan.payload.next_compact == '0)
   `DRC_ASSERT_NEXT(a_span_write, clock, reset, csr_write_enable && (csr_index == CSR_TARGET_TIMESPAN), timespan_ff == $past(csr_write_data[SPAN_W-1:0]))

endmodule
